// File: src/keystroke_line_editor_top_defines.svh
// Assertion macros for the keystroke line editor.
`ifndef KEYSTROKE_LINE_EDITOR_TOP_DEFINES_SVH
`define KEYSTROKE_LINE_EDITOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define KLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define KLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define KLE_ASSERT(lbl, prop, msg)
`define KLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/kle_pkg.sv
// Shared types and key codes of the keystroke line editor.
package kle_pkg;

    localparam int KEY_W  = 8;
    localparam int POS_W  = 7;
    localparam int KEYS_W = 26;
    localparam int KIND_W = 2;

    localparam logic [KEY_W-1:0] KEY_NEWLINE   = 8'h0A;
    localparam logic [KEY_W-1:0] KEY_TAB       = 8'h09;
    localparam logic [KEY_W-1:0] KEY_DEL       = 8'h7F;
    localparam logic [KEY_W-1:0] KEY_ESC       = 8'h1B;
    localparam logic [KEY_W-1:0] KEY_FWD       = 8'h06;
    localparam logic [KEY_W-1:0] KEY_BACK      = 8'h02;
    localparam logic [KEY_W-1:0] KEY_HOME      = 8'h01;
    localparam logic [KEY_W-1:0] KEY_END       = 8'h05;
    localparam logic [KEY_W-1:0] KEY_LAST_CTRL = 8'd26;
    localparam logic [KEY_W-1:0] KEY_BRACKET   = 8'h5B;
    localparam logic [KEY_W-1:0] CMD_OFFSET    = 8'd96;

    typedef enum logic [KIND_W-1:0] {
        EV_LINE_CHANGED   = 2'd0,
        EV_LINE_COMMITTED = 2'd1,
        EV_CURSOR_MOVED   = 2'd2,
        EV_COMMAND        = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_SEEN = 2'd1,
        ESC_CSI  = 2'd2
    } esc_phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_COMMIT,
        ACT_DELETE,
        ACT_INSERT,
        ACT_CURSOR,
        ACT_COMMAND
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_PUT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_SINGLE
    } state_t;

    typedef struct packed {
        event_kind_t        kind;
        logic [KEY_W-1:0]   char_out;
        logic               char_valid;
        logic [POS_W-1:0]   caret_pos;
        logic               last_of_run;
    } result_t;

endpackage

// File: src/keystroke_line_editor_top.sv
// Top level of the keystroke line editor.
// One keystroke byte is taken per item; the block then works on it alone and
// takes the next byte once all its result items are handed to the output
// register. Swallowed escape bytes, unregistered keys and ignored edits give
// no item; cursor and command keys give one. Newline sends the line out one
// character a cycle from the line store's read port while the output register
// is free, or one empty item for an empty line. Insert and delete first shift
// the characters behind the cursor one place through the store, one read and
// one write a cycle, then send the line out, or one empty item when a delete
// empties it. The register write channel is always ready.
module keystroke_line_editor_top
    import kle_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // key_byte[7:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // char_out[7:0], char_valid[8], caret_pos[15:9]
    output logic [KIND_W-1:0] m_tuser,   // event_kind[1:0]
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KEYS_W-1:0] cfg_data
);

    localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    logic [KEYS_W-1:0] keys_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  rd_data;
    logic              out_free;
    logic              out_load;
    result_t           out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg <= '0;
        end else if (cfg_valid) begin
            keys_reg <= cfg_data;
        end
    end

    kle_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .key_byte (s_tdata),
        .keys_i   (keys_reg),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .out_free (out_free),
        .out_load (out_load),
        .out_res  (out_res)
    );

    kle_line_mem #(
        .DEPTH  (LINE_CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kle_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (out_load),
        .res_i    (out_res),
        .free_o   (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: src/kle_line_mem.sv
// Line character store: one write port, one registered read port.
module kle_line_mem
    import kle_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/kle_out_stage.sv
// Result output register of the keystroke line editor.
`include "keystroke_line_editor_top_defines.svh"
module kle_out_stage
    import kle_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load_i,
    input  result_t           res_i,
    output logic              free_o,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,  // char_out[7:0], char_valid[8], caret_pos[15:9]
    output logic [KIND_W-1:0] m_tuser,  // event_kind[1:0]
    output logic              m_tlast
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free_o = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load_i) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= res_i;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.caret_pos, res_reg.char_valid, res_reg.char_out};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last_of_run;

    `KLE_ASSERT(a_load_when_free, load_i |-> free_o, "item loaded over a pending item")
    `KLE_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

// File: src/kle_ctrl.sv
// Keystroke decoder and line edit sequencer around the line store.
`include "keystroke_line_editor_top_defines.svh"
module kle_ctrl
    import kle_pkg::*;
#(
    parameter int LINE_CAPACITY = 64,
    parameter int ADDR_W        = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KEY_W-1:0]  key_byte,
    input  logic [KEYS_W-1:0] keys_i,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [KEY_W-1:0]  wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [KEY_W-1:0]  rd_data,
    input  logic              out_free,
    output logic              out_load,
    output result_t           out_res
);

    localparam logic [POS_W-1:0] CAP = POS_W'(LINE_CAPACITY);
    localparam logic [POS_W-1:0] ONE = POS_W'(1);

    state_t               state_reg, state_next;
    esc_phase_t           esc_reg, esc_next;
    event_kind_t          kind_reg, kind_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [KEY_W-1:0]     char_reg, char_next;
    logic                 cvalid_reg, cvalid_next;
    logic [POS_W-1:0]     len_reg, len_next;
    logic [POS_W-1:0]     cur_reg, cur_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     cnt_reg, cnt_next;
    logic [POS_W-1:0]     src_reg, src_next;
    logic [POS_W-1:0]     dst_reg, dst_next;
    logic [POS_W-1:0]     put_reg, put_next;
    logic [POS_W-1:0]     elen_reg, elen_next;
    logic [POS_W-1:0]     eidx_reg, eidx_next;
    logic                 up_reg, up_next;
    logic                 pend_reg, pend_next;

    action_t              action;
    logic                 is_ctrl;
    logic [4:0]           ctrl_bit;
    logic [POS_W-1:0]     cur_move;
    logic [POS_W-1:0]     rd_addr_full;
    logic                 emit_last;

    assign is_ctrl   = (key_reg != '0) && (key_reg <= KEY_LAST_CTRL);
    assign ctrl_bit  = key_reg[4:0] - 5'd1;
    assign emit_last = (eidx_reg + ONE) == elen_reg;

    always_comb begin
        action = ACT_NONE;
        if (esc_reg == ESC_NONE) begin
            unique case (key_reg) inside
                KEY_NEWLINE: action = ACT_COMMIT;
                KEY_TAB, KEY_DEL: begin
                    if (cur_reg != '0 && len_reg != '0) begin
                        action = ACT_DELETE;
                    end
                end
                KEY_ESC: action = ACT_NONE;
                KEY_FWD, KEY_BACK, KEY_HOME, KEY_END: action = ACT_CURSOR;
                default: begin
                    if (is_ctrl) begin
                        if (keys_i[ctrl_bit]) begin
                            action = ACT_COMMAND;
                        end
                    end else if (len_reg < CAP) begin
                        action = ACT_INSERT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        cur_move = cur_reg;
        unique case (key_reg) inside
            KEY_FWD:  if (cur_reg < len_reg) cur_move = cur_reg + ONE;
            KEY_BACK: if (cur_reg != '0) cur_move = cur_reg - ONE;
            KEY_HOME: cur_move = '0;
            KEY_END:  cur_move = len_reg;
            default:  cur_move = cur_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                unique case (action)
                    ACT_COMMIT:               state_next = S_EMIT_RD;
                    ACT_DELETE, ACT_INSERT:   state_next = S_SHIFT;
                    ACT_CURSOR, ACT_COMMAND:  state_next = S_SINGLE;
                    default:                  state_next = S_IDLE;
                endcase
            end
            S_SHIFT: begin
                if (cnt_reg == '0) state_next = up_reg ? S_PUT : S_EMIT_RD;
            end
            S_PUT:     state_next = S_EMIT_RD;
            S_EMIT_RD: state_next = (elen_reg == '0) ? S_SINGLE : S_EMIT_LD;
            S_EMIT_LD: begin
                if (out_free && emit_last) state_next = S_IDLE;
            end
            S_SINGLE: begin
                if (out_free) state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        esc_next     = esc_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        char_next    = char_reg;
        cvalid_next  = cvalid_reg;
        len_next     = len_reg;
        cur_next     = cur_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        put_next     = put_reg;
        elen_next    = elen_reg;
        eidx_next    = eidx_reg;
        up_next      = up_reg;
        pend_next    = 1'b0;
        rd_en        = 1'b0;
        rd_addr_full = src_reg;
        out_load     = 1'b0;
        out_res      = '{kind: kind_reg, char_out: char_reg, char_valid: cvalid_reg,
                         caret_pos: pos_reg, last_of_run: 1'b1};

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) key_next = key_byte;
            end
            S_DECODE: begin
                unique case (esc_reg)
                    ESC_SEEN: esc_next = (key_reg == KEY_BRACKET) ? ESC_CSI : ESC_NONE;
                    ESC_CSI:  esc_next = ESC_NONE;
                    default: begin
                        if (key_reg == KEY_ESC) esc_next = ESC_SEEN;
                    end
                endcase
                unique case (action)
                    ACT_COMMIT: begin
                        kind_next = EV_LINE_COMMITTED;
                        elen_next = len_reg;
                        pos_next  = '0;
                        len_next  = '0;
                        cur_next  = '0;
                    end
                    ACT_DELETE: begin
                        kind_next = EV_LINE_CHANGED;
                        cnt_next  = len_reg - cur_reg;
                        src_next  = cur_reg;
                        up_next   = 1'b0;
                        len_next  = len_reg - ONE;
                        cur_next  = cur_reg - ONE;
                        pos_next  = cur_reg - ONE;
                        elen_next = len_reg - ONE;
                    end
                    ACT_INSERT: begin
                        kind_next = EV_LINE_CHANGED;
                        cnt_next  = len_reg - cur_reg;
                        src_next  = len_reg - ONE;
                        up_next   = 1'b1;
                        put_next  = cur_reg;
                        len_next  = len_reg + ONE;
                        cur_next  = cur_reg + ONE;
                        pos_next  = cur_reg + ONE;
                        elen_next = len_reg + ONE;
                    end
                    ACT_CURSOR: begin
                        kind_next   = EV_CURSOR_MOVED;
                        char_next   = '0;
                        cvalid_next = 1'b0;
                        cur_next    = cur_move;
                        pos_next    = cur_move;
                    end
                    ACT_COMMAND: begin
                        kind_next   = EV_COMMAND;
                        char_next   = key_reg + CMD_OFFSET;
                        cvalid_next = 1'b1;
                        pos_next    = cur_reg;
                    end
                    default: ;
                endcase
            end
            S_SHIFT: begin
                if (cnt_reg != '0) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    dst_next  = up_reg ? src_reg + ONE : src_reg - ONE;
                    src_next  = up_reg ? src_reg - ONE : src_reg + ONE;
                    cnt_next  = cnt_reg - ONE;
                end
            end
            S_EMIT_RD: begin
                if (elen_reg == '0) begin
                    char_next   = '0;
                    cvalid_next = 1'b0;
                end else begin
                    rd_en        = 1'b1;
                    rd_addr_full = '0;
                    eidx_next    = '0;
                end
            end
            S_EMIT_LD: begin
                out_res.char_out    = rd_data;
                out_res.char_valid  = 1'b1;
                out_res.last_of_run = emit_last;
                if (out_free) begin
                    out_load = 1'b1;
                    if (!emit_last) begin
                        rd_en        = 1'b1;
                        rd_addr_full = eidx_reg + ONE;
                        eidx_next    = eidx_reg + ONE;
                    end
                end
            end
            S_SINGLE: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = dst_reg[ADDR_W-1:0];
        wr_data = rd_data;
        if (pend_reg) begin
            wr_en = 1'b1;
        end else if (state_reg == S_PUT) begin
            wr_en   = 1'b1;
            wr_addr = put_reg[ADDR_W-1:0];
            wr_data = key_reg;
        end
    end

    assign rd_addr  = rd_addr_full[ADDR_W-1:0];
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            esc_reg   <= ESC_NONE;
            len_reg   <= '0;
            cur_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        char_reg   <= char_next;
        cvalid_reg <= cvalid_next;
        pos_reg    <= pos_next;
        cnt_reg    <= cnt_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        put_reg    <= put_next;
        elen_reg   <= elen_next;
        eidx_reg   <= eidx_next;
        up_reg     <= up_next;
    end

    `KLE_ASSERT(a_no_rw_overlap, rd_en && wr_en |-> rd_addr != wr_addr, "read and write hit one entry")
    `KLE_ASSERT(a_line_bounds, cur_reg <= len_reg && len_reg <= CAP, "cursor or length out of range")
    `KLE_ASSERT(a_emit_in_line, state_reg == S_EMIT_LD |-> eidx_reg < elen_reg, "emit past line end")
    `KLE_ASSERT(a_shift_write, pend_reg |-> $past(state_reg) == S_SHIFT, "stray shift write")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the keystroke line editor: directed table, then random keystrokes.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kle_pkg::*;

    localparam int LINE_CAP      = 64;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [KEYS_W-1:0] ALL_KEYS  = '1;
    localparam logic [KEYS_W-1:0] NO_KEYS   = '0;
    localparam logic [KEYS_W-1:0] ODD_KEYS  = 26'h2AAAAAA;
    localparam logic [KEYS_W-1:0] EVEN_KEYS = 26'h1555555;
    localparam logic [7:0] RX_PATTERN = 8'b1101_0110;

    typedef struct {
        bit                write_mask;
        logic [KEYS_W-1:0] mask;
        logic [KEY_W-1:0]  key;
        bit                typed;
        bit                has_result;
        result_t           res;
    } key_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;   // key_byte[7:0]
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;          // char_out[7:0], char_valid[8], caret_pos[15:9]
    logic [KIND_W-1:0] m_tuser;          // event_kind[1:0]
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [KEYS_W-1:0] cfg_data  = '0;

    logic [KEY_W-1:0]  line_buf [LINE_CAP];
    int                line_len   = 0;
    int                cursor_at  = 0;
    esc_phase_t        esc_state  = ESC_NONE;
    logic [KEYS_W-1:0] key_mask   = '0;

    result_t  step_results[$];
    result_t  expected_events[$];
    key_row_t directed_rows[$];

    int burst_left    = 0;
    int keys_sent     = 0;
    int results_seen  = 0;
    int mask_writes   = 0;
    int full_drops    = 0;
    int mismatches    = 0;
    int rx_tick       = 0;
    int rx_mode       = 0;

    keystroke_line_editor_top #(.LINE_CAPACITY(LINE_CAP)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        rx_tick++;
        if (rx_tick % 97 == 0) begin
            rx_mode = $urandom_range(0, 2);
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= RX_PATTERN[rx_tick % 8];
        endcase
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind        = event_kind_t'(m_tuser);
            got.char_out    = m_tdata[7:0];
            got.char_valid  = m_tdata[8];
            got.caret_pos   = m_tdata[15:9];
            got.last_of_run = m_tlast;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: kind %0d char %02h valid %0b pos %0d last %0b",
                             got.kind, got.char_out, got.char_valid, got.caret_pos,
                             got.last_of_run);
                end
            end else begin
                want = expected_events.pop_front();
                results_seen++;
                if (got.kind !== want.kind || got.char_out !== want.char_out ||
                    got.char_valid !== want.char_valid || got.caret_pos !== want.caret_pos ||
                    got.last_of_run !== want.last_of_run) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: expected kind %0d char %02h valid %0b pos %0d last %0b,",
                               want.kind, want.char_out, want.char_valid, want.caret_pos,
                               want.last_of_run);
                        $display(" got kind %0d char %02h valid %0b pos %0d last %0b",
                                 got.kind, got.char_out, got.char_valid, got.caret_pos,
                                 got.last_of_run);
                    end
                end
            end
        end
    end

    function automatic void add_result(event_kind_t kind, logic [KEY_W-1:0] ch, logic valid,
                                       int pos, logic last);
        result_t r;
        r.kind        = kind;
        r.char_out    = ch;
        r.char_valid  = valid;
        r.caret_pos   = POS_W'(pos);
        r.last_of_run = last;
        step_results.push_back(r);
    endfunction

    function automatic void echo_line(event_kind_t kind, int pos);
        if (line_len == 0) begin
            add_result(kind, 8'h00, 1'b0, pos, 1'b1);
        end else begin
            for (int i = 0; i < line_len; i++) begin
                add_result(kind, line_buf[i], 1'b1, pos, i == line_len - 1);
            end
        end
    endfunction

    function automatic void edit_line(input logic [KEY_W-1:0] k);
        step_results.delete();
        if (esc_state == ESC_SEEN) begin
            esc_state = (k == KEY_BRACKET) ? ESC_CSI : ESC_NONE;
        end else if (esc_state != ESC_NONE) begin
            esc_state = ESC_NONE;
        end else begin
            case (k)
                KEY_NEWLINE: begin
                    echo_line(EV_LINE_COMMITTED, 0);
                    line_len  = 0;
                    cursor_at = 0;
                end
                KEY_TAB, KEY_DEL: begin
                    if (cursor_at != 0 && line_len != 0) begin
                        for (int i = cursor_at - 1; i < line_len - 1; i++) begin
                            line_buf[i] = line_buf[i + 1];
                        end
                        line_len--;
                        cursor_at--;
                        echo_line(EV_LINE_CHANGED, cursor_at);
                    end
                end
                KEY_ESC: esc_state = ESC_SEEN;
                KEY_FWD: begin
                    if (cursor_at < line_len) cursor_at++;
                    add_result(EV_CURSOR_MOVED, 8'h00, 1'b0, cursor_at, 1'b1);
                end
                KEY_BACK: begin
                    if (cursor_at > 0) cursor_at--;
                    add_result(EV_CURSOR_MOVED, 8'h00, 1'b0, cursor_at, 1'b1);
                end
                KEY_HOME: begin
                    cursor_at = 0;
                    add_result(EV_CURSOR_MOVED, 8'h00, 1'b0, cursor_at, 1'b1);
                end
                KEY_END: begin
                    cursor_at = line_len;
                    add_result(EV_CURSOR_MOVED, 8'h00, 1'b0, cursor_at, 1'b1);
                end
                default: begin
                    if (k >= 8'd1 && k <= KEY_LAST_CTRL) begin
                        if (key_mask[k - 8'd1]) begin
                            add_result(EV_COMMAND, k + CMD_OFFSET, 1'b1, cursor_at, 1'b1);
                        end
                    end else if (line_len >= LINE_CAP) begin
                        full_drops++;
                    end else begin
                        for (int i = line_len; i > cursor_at; i--) begin
                            line_buf[i] = line_buf[i - 1];
                        end
                        line_buf[cursor_at] = k;
                        line_len++;
                        cursor_at++;
                        echo_line(EV_LINE_CHANGED, cursor_at);
                    end
                end
            endcase
        end
    endfunction

    function automatic result_t single(event_kind_t kind, logic [KEY_W-1:0] ch, logic valid,
                                       int pos);
        result_t r;
        r.kind        = kind;
        r.char_out    = ch;
        r.char_valid  = valid;
        r.caret_pos   = POS_W'(pos);
        r.last_of_run = 1'b1;
        return r;
    endfunction

    function automatic void add_row(bit write_mask, logic [KEYS_W-1:0] mask,
                                    logic [KEY_W-1:0] k, bit typed, bit has_result,
                                    result_t res);
        key_row_t row;
        row.write_mask = write_mask;
        row.mask       = mask;
        row.key        = k;
        row.typed      = typed;
        row.has_result = has_result;
        row.res        = res;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [KEY_W-1:0] pick_insert_key();
        logic [KEY_W-1:0] k;
        do begin
            k = KEY_W'($urandom_range(0, 255));
        end while ((k >= 8'd1 && k <= KEY_ESC) || k == KEY_DEL);
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pick_cursor_key();
        case ($urandom_range(0, 3))
            0: return KEY_FWD;
            1: return KEY_BACK;
            2: return KEY_HOME;
            default: return KEY_END;
        endcase
    endfunction

    task automatic send_key(input logic [KEY_W-1:0] k, input bit typed, input bit has_result,
                            input result_t res);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        keys_sent++;
        edit_line(k);
        if (typed) begin
            if (has_result) expected_events.push_back(res);
        end else begin
            foreach (step_results[i]) expected_events.push_back(step_results[i]);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_key_mask(input logic [KEYS_W-1:0] mask);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        do @(posedge aclk); while (!cfg_ready);
        key_mask = mask;
        mask_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [KEYS_W-1:0] mask, input bit fill, input int count);
        logic [KEY_W-1:0] burst_keys[$];
        int r;
        drain_results();
        write_key_mask(mask);
        for (int n = 0; n < count; n += burst_keys.size()) begin
            r = $urandom_range(0, 99);
            burst_keys.delete();
            if (fill) begin
                if (r < 88) burst_keys.push_back(pick_insert_key());
                else if (r < 91) burst_keys.push_back($urandom_range(0, 1) ? KEY_TAB : KEY_DEL);
                else burst_keys.push_back(pick_cursor_key());
            end else if (r < 48) begin
                burst_keys.push_back(pick_insert_key());
            end else if (r < 56) begin
                burst_keys.push_back(KEY_NEWLINE);
            end else if (r < 64) begin
                burst_keys.push_back($urandom_range(0, 1) ? KEY_TAB : KEY_DEL);
            end else if (r < 76) begin
                burst_keys.push_back(pick_cursor_key());
            end else if (r < 85) begin
                burst_keys.push_back(KEY_W'($urandom_range(1, 26)));
            end else if (r < 93) begin
                burst_keys.push_back(KEY_ESC);
                if ($urandom_range(0, 1)) burst_keys.push_back(KEY_BRACKET);
                burst_keys.push_back(KEY_W'($urandom_range(0, 255)));
            end else begin
                burst_keys.push_back(KEY_W'($urandom_range(0, 255)));
            end
            foreach (burst_keys[i]) send_key(burst_keys[i], 1'b0, 1'b0, '0);
        end
    endtask

    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        add_row(0, NO_KEYS, KEY_DEL,     1, 0, '0);
        add_row(0, NO_KEYS, KEY_FWD,     1, 1, single(EV_CURSOR_MOVED, 8'h00, 1'b0, 0));
        add_row(0, NO_KEYS, KEY_BACK,    1, 1, single(EV_CURSOR_MOVED, 8'h00, 1'b0, 0));
        add_row(0, NO_KEYS, 8'h03,       1, 0, '0);
        add_row(0, NO_KEYS, 8'h1A,       1, 0, '0);
        add_row(0, NO_KEYS, KEY_NEWLINE, 1, 1, single(EV_LINE_COMMITTED, 8'h00, 1'b0, 0));
        add_row(0, NO_KEYS, 8'h00,       1, 1, single(EV_LINE_CHANGED, 8'h00, 1'b1, 1));
        add_row(0, NO_KEYS, 8'hFF,       0, 0, '0);
        add_row(0, NO_KEYS, 8'h80,       0, 0, '0);
        add_row(0, NO_KEYS, KEY_HOME,    1, 1, single(EV_CURSOR_MOVED, 8'h00, 1'b0, 0));
        add_row(0, NO_KEYS, 8'h41,       0, 0, '0);
        add_row(0, NO_KEYS, KEY_END,     0, 0, '0);
        add_row(0, NO_KEYS, KEY_BACK,    0, 0, '0);
        add_row(0, NO_KEYS, KEY_TAB,     0, 0, '0);
        add_row(0, NO_KEYS, KEY_DEL,     0, 0, '0);
        add_row(0, NO_KEYS, KEY_FWD,     0, 0, '0);
        add_row(0, NO_KEYS, KEY_ESC,     1, 0, '0);
        add_row(0, NO_KEYS, KEY_BRACKET, 1, 0, '0);
        add_row(0, NO_KEYS, KEY_NEWLINE, 1, 0, '0);
        add_row(0, NO_KEYS, KEY_ESC,     1, 0, '0);
        add_row(0, NO_KEYS, KEY_DEL,     1, 0, '0);
        add_row(0, NO_KEYS, KEY_NEWLINE, 0, 0, '0);
        add_row(1, ALL_KEYS, 8'h1A,      1, 1, single(EV_COMMAND, 8'd122, 1'b1, 0));
        add_row(0, ALL_KEYS, 8'h03,      1, 1, single(EV_COMMAND, 8'd99, 1'b1, 0));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].write_mask) begin
                drain_results();
                write_key_mask(directed_rows[i].mask);
            end
            send_key(directed_rows[i].key, directed_rows[i].typed,
                     directed_rows[i].has_result, directed_rows[i].res);
        end

        run_phase(ALL_KEYS, 1'b0, 80);
        run_phase(KEYS_W'($urandom()), 1'b1, 100);
        run_phase(NO_KEYS, 1'b0, 70);
        run_phase(ODD_KEYS, 1'b0, 70);
        run_phase(EVEN_KEYS, 1'b0, 70);
        drain_results();
        mismatches += expected_events.size();

        $display("covered %0d keystrokes and %0d result items over %0d key mask settings",
                 keys_sent, results_seen, mask_writes + 1);
        $display("inserts dropped on a full line: %0d, mismatches: %0d", full_drops, mismatches);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/kle_pkg.sv
src/kle_line_mem.sv
src/kle_out_stage.sv
src/kle_ctrl.sv
src/keystroke_line_editor_top.sv
verif/testbench.sv
